// ===== rtl/core/b64lb_pkg.sv =====
// shared types, constants and alphabet lookup for the base64 line-break encoder
`default_nettype none
package b64lb_pkg;

	localparam logic [7:0] GPL_RESET = 8'd19;
	localparam logic [7:0] CH_PAD    = 8'd61;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_LF     = 8'd10;
	localparam int         QDEPTH    = 2;

	// position of the next byte within its three-byte group
	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_THIRD  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} out_item_t;

	// characters caused by one byte, emitted from index 0 up to last_idx
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic [1:0]      last_idx;
		logic            msg_last;
	} job_t;

	function automatic logic [7:0] sym(input logic [5:0] v);
		logic [7:0] r;
		if (v < 6'd26) begin
			r = 8'd65 + {2'b00, v};
		end else if (v < 6'd52) begin
			r = 8'd71 + {2'b00, v};
		end else if (v < 6'd62) begin
			r = 8'd48 + {2'b00, v - 6'd52};
		end else if (v == 6'd62) begin
			r = 8'd43;
		end else begin
			r = 8'd47;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/b64lb_front.sv =====
// front end: takes bytes, tracks group and line position, builds character jobs
`default_nettype none
module b64lb_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [7:0]          cfg_wdata,
	input  wire logic                take,
	input  wire b64lb_pkg::in_item_t item,
	output b64lb_pkg::job_t          job
);

	logic [7:0]        gpl_q;
	b64lb_pkg::phase_t phase_q;
	logic [3:0]        carry_q;
	logic [7:0]        line_q;

	b64lb_pkg::phase_t phase_d;
	logic [3:0]        carry_d;
	logic [7:0]        line_d;
	logic [7:0]        line_inc;
	logic [7:0]        b;

	assign b        = item.in_byte;
	assign line_inc = line_q + 8'd1;

	always_comb begin
		job          = '0;
		job.msg_last = item.is_last;
		phase_d      = phase_q;
		carry_d      = carry_q;
		line_d       = line_q;
		case (phase_q)
			b64lb_pkg::PH_SECOND: begin
				job.chars[0] = b64lb_pkg::sym({carry_q[1:0], b[7:4]});
				job.chars[1] = b64lb_pkg::sym({b[3:0], 2'b00});
				job.chars[2] = b64lb_pkg::CH_PAD;
				job.last_idx = item.is_last ? 2'd2 : 2'd0;
				carry_d      = b[3:0];
				phase_d      = b64lb_pkg::PH_THIRD;
			end
			b64lb_pkg::PH_THIRD: begin
				job.chars[0] = b64lb_pkg::sym({carry_q, b[7:6]});
				job.chars[1] = b64lb_pkg::sym(b[5:0]);
				job.chars[2] = b64lb_pkg::CH_CR;
				job.chars[3] = b64lb_pkg::CH_LF;
				carry_d      = 4'd0;
				phase_d      = b64lb_pkg::PH_FIRST;
				if (line_inc == gpl_q) begin
					job.last_idx = 2'd3;
					line_d       = 8'd0;
				end else begin
					job.last_idx = 2'd1;
					line_d       = line_inc;
				end
			end
			default: begin
				// first byte of a group; any illegal code is handled the same way
				job.chars[0] = b64lb_pkg::sym(b[7:2]);
				job.chars[1] = b64lb_pkg::sym({b[1:0], 4'b0000});
				job.chars[2] = b64lb_pkg::CH_PAD;
				job.chars[3] = b64lb_pkg::CH_PAD;
				job.last_idx = item.is_last ? 2'd3 : 2'd0;
				carry_d      = {2'b00, b[1:0]};
				phase_d      = b64lb_pkg::PH_SECOND;
			end
		endcase
		if (item.is_last) begin
			phase_d = b64lb_pkg::PH_FIRST;
			carry_d = 4'd0;
			line_d  = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gpl_q   <= b64lb_pkg::GPL_RESET;
			phase_q <= b64lb_pkg::PH_FIRST;
			carry_q <= 4'd0;
			line_q  <= 8'd0;
		end else begin
			if (cfg_we) begin
				gpl_q <= cfg_wdata;
			end
			if (take) begin
				phase_q <= phase_d;
				carry_q <= carry_d;
				line_q  <= line_d;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/b64lb_queue.sv =====
// two-entry job queue between front and back
`default_nettype none
module b64lb_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64lb_pkg::job_t  push_job,
	output logic                  full,
	input  wire logic             pop,
	output logic                  avail,
	output b64lb_pkg::job_t       head
);

	localparam int PW = $clog2(b64lb_pkg::QDEPTH);

	b64lb_pkg::job_t      mem_q [b64lb_pkg::QDEPTH];
	logic [PW-1:0]        wr_q;
	logic [PW-1:0]        rd_q;
	logic [PW:0]          cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full    = (cnt_q == (PW+1)'(b64lb_pkg::QDEPTH));
	assign avail   = (cnt_q != '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/b64lb_back.sv =====
// back end: walks each job's characters into the output register
`default_nettype none
module b64lb_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_avail,
	input  wire b64lb_pkg::job_t   q_head,
	output logic                   q_pop,
	output logic                   char_valid,
	input  wire logic              char_stall,
	output b64lb_pkg::out_item_t   char_item
);

	b64lb_pkg::job_t      job_q;
	logic                 busy_q;
	logic [1:0]           idx_q;
	logic                 ov_q;
	b64lb_pkg::out_item_t oitem_q;

	logic adv;
	logic done;

	// output register can take a new character
	assign adv   = !ov_q || !char_stall;
	assign done  = busy_q && adv && (idx_q == job_q.last_idx);
	assign q_pop = q_avail && (!busy_q || done);

	assign char_valid = ov_q;
	assign char_item  = oitem_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
		if (busy_q && adv) begin
			oitem_q.out_char <= job_q.chars[idx_q];
			oitem_q.out_last <= job_q.msg_last && (idx_q == job_q.last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
			ov_q   <= 1'b0;
		end else begin
			if (adv) begin
				ov_q <= busy_q;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (done) begin
				busy_q <= 1'b0;
				idx_q  <= 2'd0;
			end else if (busy_q && adv) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/base64_encoder_line_breaks.sv =====
// top level of the base64 encoder with CR LF line breaks
//
//  channel  signals                               width  role
//  byte     byte_valid, byte_stall, byte_item      9     message bytes in, last flag
//  char     char_valid, char_stall, char_item      9     characters out, last flag
//  cfg      cfg_we, cfg_wdata                      8     groups per line, reset 19
//
// a byte is taken whenever the two-entry job queue has room
// the back end sends one character per cycle while char_stall is low; a byte yields
// one to four characters; sustained rate is set by the single character output port
// reset empties the queue and output register and clears group and line position
// a stall on the char side fills the queue, then raises byte_stall
`default_nettype none
module base64_encoder_line_breaks (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 byte_valid,
	output logic                      byte_stall,
	input  wire b64lb_pkg::in_item_t  byte_item,
	output logic                      char_valid,
	input  wire logic                 char_stall,
	output b64lb_pkg::out_item_t      char_item,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_wdata
);

	b64lb_pkg::job_t new_job;
	b64lb_pkg::job_t head_job;
	logic            q_full;
	logic            q_avail;
	logic            q_pop;
	logic            take;

	assign byte_stall = q_full;
	assign take       = byte_valid && !q_full;

	b64lb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.item      (byte_item),
		.job       (new_job)
	);

	b64lb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_job (new_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (head_job)
	);

	b64lb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_avail    (q_avail),
		.q_head     (head_job),
		.q_pop      (q_pop),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_item  (char_item)
	);

endmodule
`default_nettype wire
